// ----- design/scfd_pkg.sv -----
// ----------------------------------------------------------------------------
// scfd_pkg
// Shared constants and types for the serial command frame decoder.
// ----------------------------------------------------------------------------
package scfd_pkg;

   localparam int unsigned FRAME_DEPTH = 5;
   localparam int unsigned POS_W       = 3;

   localparam logic [7:0] CH_START = 8'h21;  // '!'
   localparam logic [7:0] CH_END   = 8'h23;  // '#'
   localparam logic [7:0] CH_L     = 8'h6c;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_O     = 8'h6f;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_EIGHT = 8'h38;

   localparam logic [1:0] SAMPLE_NONE = 2'd0;
   localparam logic [1:0] SAMPLE_CH0  = 2'd1;
   localparam logic [1:0] SAMPLE_CH1  = 2'd2;

   typedef struct packed {
      logic [7:0] led_state;
      logic [1:0] sample_request;
      logic       frame_end;
   } result_type;

endpackage

// ----- design/scfd_in_stage.sv -----
// ----------------------------------------------------------------------------
// scfd_in_stage
// Input register for received bytes, with valid tracking and stall logic.
// ----------------------------------------------------------------------------
module scfd_in_stage
   import scfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   assign in_ready   = !valid_ff || advance;
   assign valid_in   = (in_valid && in_ready) || (valid_ff && !advance);
   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
      end
   end

endmodule

// ----- design/scfd_decoder.sv -----
// ----------------------------------------------------------------------------
// scfd_decoder
// Frame buffer, write position and LED register; decodes one byte per step.
// ----------------------------------------------------------------------------
module scfd_decoder
   import scfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output result_type result
);

   logic [7:0]       buf_ff [FRAME_DEPTH];
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       led_ff, led_in;
   logic [7:0]       eff [FRAME_DEPTH];
   logic             in_range;
   logic             is_led, is_pot;
   logic [7:0]       arg;
   logic [2:0]       bit_idx;
   logic [1:0]       request;
   logic             closed;

   assign in_range = pos_ff < POS_W'(FRAME_DEPTH);

   // buffer as it stands once this byte is written
   always_comb begin
      for (int i = 0; i < FRAME_DEPTH; i++) begin
         eff[i] = (in_range && pos_ff == POS_W'(i)) ? rx_byte : buf_ff[i];
      end
   end

   assign arg     = eff[4];
   assign bit_idx = 3'(arg - CH_ONE);
   assign is_led  = eff[1] == CH_L && eff[2] == CH_E && eff[3] == CH_D;
   assign is_pot  = eff[1] == CH_P && eff[2] == CH_O && eff[3] == CH_T;

   always_comb begin
      pos_in  = pos_ff;
      led_in  = led_ff;
      request = SAMPLE_NONE;
      closed  = 1'b0;
      if (eff[0] != CH_START) begin
         pos_in = '0;
      end else if (rx_byte == CH_END) begin
         closed = 1'b1;
         pos_in = '0;
         if (is_led) begin
            if (arg == CH_ZERO) begin
               led_in = '0;
            end else if (arg inside {[CH_ONE:CH_EIGHT]}) begin
               led_in = led_ff ^ (8'd1 << bit_idx);
            end
         end else if (is_pot) begin
            if (arg == CH_ZERO) begin
               request = SAMPLE_CH0;
            end else if (arg == CH_ONE) begin
               request = SAMPLE_CH1;
            end
         end
      end else begin
         pos_in = in_range ? pos_ff + POS_W'(1) : '0;
      end
   end

   assign result.led_state      = led_in;
   assign result.sample_request = request;
   assign result.frame_end      = closed;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         led_ff <= '0;
      end else if (step) begin
         pos_ff <= pos_in;
         led_ff <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_range) begin
         buf_ff[pos_ff] <= rx_byte;
      end
   end

endmodule

// ----- design/serial_command_frame_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// serial_command_frame_decoder_unit
// Decodes '!led<d>#' and '!pot<d>#' command frames from a serial byte stream.
// Path: the input transfer goes to the input reg, then the result reg drives
// rsp_tvalid; an output stall can hold the byte in the input reg meanwhile.
// Throughput: one byte per cycle if rsp_tready allows; decode is between regs.
// Reset: position and LED register cleared; frame buffer is not cleared.
// ----------------------------------------------------------------------------
module serial_command_frame_decoder_unit
   import scfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] led_state, [9:8] sample_request
   output logic        rsp_tlast    // frame_end
);

   logic       held_valid;
   logic [7:0] held_byte;
   logic       advance;
   result_type result;
   result_type out_ff;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;

   assign out_free     = !out_valid_ff || rsp_tready;
   assign advance      = held_valid && out_free;
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   scfd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   scfd_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (held_byte),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.sample_request, out_ff.led_state};
   assign rsp_tlast  = out_ff.frame_end;

endmodule
